/* rtl/slic_pixel_assign_update_top_defines.svh */
// Assertion macros shared by the checker.
`ifndef SLIC_PIXEL_ASSIGN_UPDATE_TOP_DEFINES_SVH
`define SLIC_PIXEL_ASSIGN_UPDATE_TOP_DEFINES_SVH

// Clocked check, off while reset is high.
`define SPAU_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs across reset.
`define SPAU_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/spau_pkg.sv */
`default_nettype none
package spau_pkg;

   localparam int NUM_CENTERS = 64;
   localparam int IDX_BITS    = $clog2(NUM_CENTERS);
   localparam int ADDR_BITS   = IDX_BITS + 1;
   localparam int COORD_BITS  = 10;
   localparam int LABEL_BITS  = 6;
   localparam int DIV_STEPS   = 30;
   localparam int DIVC_BITS   = $clog2(DIV_STEPS + 1);
   localparam int DIV_LANES   = 5;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_CLASSIFY = 2'd1;
   localparam logic [1:0] OP_UPDATE   = 2'd2;

   localparam logic CSR_GRID_STEP   = 1'b0;
   localparam logic CSR_COMPACTNESS = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_SCAN, ST_DRAIN, ST_ACC_RD, ST_ACC_WR,
      ST_UPD_RD, ST_UPD_CHK, ST_UPD_DIV, ST_UPD_WR, ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 accept;
      logic                 prep;
      logic                 scan_issue;
      logic [IDX_BITS-1:0]  addr;
      logic                 acc_rd;
      logic                 acc_from_best;
      logic                 acc_wr;
      logic                 div_start;
      logic                 div_step;
      logic                 upd_wr;
      logic                 rsp_load;
      logic                 rsp_classify;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic count_zero;
   } status_type;

endpackage
`default_nettype wire

/* rtl/spau_ctrl.sv */
`default_nettype none
module spau_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_op,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output spau_pkg::cmd_type       cmd,
   input  wire spau_pkg::status_type sts
);

   spau_pkg::state_type                state_ff, state_in;
   logic [spau_pkg::ADDR_BITS-1:0]     addr_ff, addr_in;
   logic [spau_pkg::DIVC_BITS-1:0]     divcnt_ff, divcnt_in;
   logic [1:0]                         op_ff, op_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               last_addr;
   logic                               out_free;

   assign last_addr = (addr_ff == spau_pkg::ADDR_BITS'(spau_pkg::NUM_CENTERS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != spau_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spau_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  spau_pkg::OP_CLASSIFY: state_in = spau_pkg::ST_PREP;
                  spau_pkg::OP_UPDATE:   state_in = spau_pkg::ST_UPD_RD;
                  default:               state_in = spau_pkg::ST_FINISH;
               endcase
            end
         end
         spau_pkg::ST_PREP:    state_in = spau_pkg::ST_SCAN;
         spau_pkg::ST_SCAN:    if (last_addr) state_in = spau_pkg::ST_DRAIN;
         spau_pkg::ST_DRAIN:   if (!sts.pipe_busy) state_in = spau_pkg::ST_ACC_RD;
         spau_pkg::ST_ACC_RD:  state_in = spau_pkg::ST_ACC_WR;
         spau_pkg::ST_ACC_WR:  state_in = spau_pkg::ST_FINISH;
         spau_pkg::ST_UPD_RD:  state_in = spau_pkg::ST_UPD_CHK;
         spau_pkg::ST_UPD_CHK: begin
            state_in = sts.count_zero ? spau_pkg::ST_UPD_WR : spau_pkg::ST_UPD_DIV;
         end
         spau_pkg::ST_UPD_DIV: begin
            if (divcnt_ff == spau_pkg::DIVC_BITS'(spau_pkg::DIV_STEPS - 1))
               state_in = spau_pkg::ST_UPD_WR;
         end
         spau_pkg::ST_UPD_WR:  state_in = last_addr ? spau_pkg::ST_FINISH : spau_pkg::ST_UPD_RD;
         spau_pkg::ST_FINISH:  if (out_free) state_in = spau_pkg::ST_IDLE;
         default:              state_in = spau_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.addr         = addr_ff[spau_pkg::IDX_BITS-1:0];
      cmd.rsp_classify = (op_ff == spau_pkg::OP_CLASSIFY);
      addr_in          = addr_ff;
      divcnt_in        = divcnt_ff;
      op_in            = op_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      case (state_ff)
         spau_pkg::ST_IDLE: begin
            cmd.accept = req_valid;
            addr_in    = '0;
            if (req_valid) op_in = req_op;
         end
         spau_pkg::ST_PREP: cmd.prep = 1'b1;
         spau_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            addr_in        = addr_ff + 1'b1;
         end
         spau_pkg::ST_ACC_RD: begin
            cmd.acc_rd        = 1'b1;
            cmd.acc_from_best = 1'b1;
         end
         spau_pkg::ST_ACC_WR: cmd.acc_wr = 1'b1;
         spau_pkg::ST_UPD_RD: cmd.acc_rd = 1'b1;
         spau_pkg::ST_UPD_CHK: begin
            cmd.div_start = 1'b1;
            divcnt_in     = '0;
         end
         spau_pkg::ST_UPD_DIV: begin
            cmd.div_step = 1'b1;
            divcnt_in    = divcnt_ff + 1'b1;
         end
         spau_pkg::ST_UPD_WR: begin
            cmd.upd_wr = 1'b1;
            addr_in    = addr_ff + 1'b1;
         end
         spau_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spau_pkg::ST_IDLE;
         addr_ff      <= '0;
         divcnt_ff    <= '0;
         op_ff        <= spau_pkg::OP_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         divcnt_ff    <= divcnt_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/spau_dp.sv */
`default_nettype none
module spau_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [5:0]           req_center_index,
   input  wire logic [9:0]           req_pos_x,
   input  wire logic [9:0]           req_pos_y,
   input  wire logic [7:0]           req_lum,
   input  wire logic [7:0]           req_chroma_a,
   input  wire logic [7:0]           req_chroma_b,
   input  wire logic [1:0]           req_op,
   input  wire logic                 csr_we,
   input  wire logic                 csr_addr,
   input  wire logic [9:0]           csr_wdata,
   input  wire spau_pkg::cmd_type    cmd,
   output spau_pkg::status_type      sts,
   output logic [5:0]                rsp_label,
   output logic                      rsp_no_center_near,
   output logic [39:0]               rsp_best_distance
);

   typedef struct packed {
      logic [9:0] x;
      logic [9:0] y;
      logic [7:0] l;
      logic [7:0] a;
      logic [7:0] b;
   } cen_type;

   typedef struct packed {
      logic [29:0] x;
      logic [29:0] y;
      logic [27:0] l;
      logic [27:0] a;
      logic [27:0] b;
      logic [20:0] cnt;
   } acc_type;

   function automatic logic [9:0] absd10(input logic [9:0] p, input logic [9:0] q);
      return (p > q) ? p - q : q - p;
   endfunction

   function automatic logic [7:0] absd8(input logic [7:0] p, input logic [7:0] q);
      return (p > q) ? p - q : q - p;
   endfunction

   localparam int N = spau_pkg::NUM_CENTERS;
   localparam int IB = spau_pkg::IDX_BITS;

   logic [9:0]  grid_ff;
   logic [7:0]  comp_ff;
   logic [19:0] s2_ff;
   logic [15:0] m2_ff;
   cen_type     pix_ff;

   cen_type     cen_mem [N];
   logic [N-1:0] cen_vld_ff;
   cen_type     cen_rd_ff;
   logic        cen_rdv_ff;
   cen_type     cen_eff;

   acc_type     acc_mem [N];
   logic [N-1:0] acc_vld_ff;
   acc_type     acc_rd_ff;
   logic        acc_rdv_ff;
   acc_type     acc_eff;
   acc_type     acc_sum;
   logic [IB-1:0] acc_raddr;

   logic        load_ok;

   // scan pipeline
   logic        v0_ff, v1_ff, v2_ff, v3_ff;
   logic [IB-1:0] k0_ff, k1_ff, k2_ff, k3_ff;
   logic        w1_ff, w2_ff, w3_ff;
   logic [9:0]  dx1_ff, dy1_ff;
   logic [7:0]  dl1_ff, da1_ff, db1_ff;
   logic [17:0] dc2_ff;
   logic [20:0] ds2_ff;
   logic [37:0] pc_ff;
   logic [36:0] ps_ff;
   logic [38:0] key;
   logic        found_ff;
   logic [38:0] best_ff;
   logic [IB-1:0] bestk_ff;

   // divider lanes
   logic [29:0] dvd_ff [spau_pkg::DIV_LANES];
   logic [20:0] rem_ff [spau_pkg::DIV_LANES];
   logic [29:0] dvd_in [spau_pkg::DIV_LANES];
   logic [20:0] rem_in [spau_pkg::DIV_LANES];
   logic [20:0] dsr_ff;
   logic [21:0] trial;
   cen_type     mean;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= 10'd16;
         comp_ff <= 8'd10;
      end else if (csr_we) begin
         case (csr_addr)
            spau_pkg::CSR_GRID_STEP:   grid_ff <= csr_wdata;
            spau_pkg::CSR_COMPACTNESS: comp_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // latch the pixel and the squared normalizers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= '{x: req_pos_x, y: req_pos_y, l: req_lum, a: req_chroma_a, b: req_chroma_b};
      end
      if (cmd.prep) begin
         s2_ff <= grid_ff * grid_ff;
         m2_ff <= comp_ff * comp_ff;
      end
   end

   // center table
   assign load_ok = cmd.accept && (req_op == spau_pkg::OP_LOAD) &&
                    (32'(req_center_index) < N);

   always_ff @(posedge clock) begin
      if (load_ok) begin
         cen_mem[IB'(req_center_index)] <=
            '{x: req_pos_x, y: req_pos_y, l: req_lum, a: req_chroma_a, b: req_chroma_b};
      end else if (cmd.upd_wr && !acc_eff.cnt[0] && acc_eff.cnt == '0) begin
      end else if (cmd.upd_wr) begin
         cen_mem[cmd.addr] <= mean;
      end
      cen_rd_ff <= cen_mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_vld_ff <= '0;
         cen_rdv_ff <= 1'b0;
      end else begin
         if (load_ok) cen_vld_ff[IB'(req_center_index)] <= 1'b1;
         else if (cmd.upd_wr && acc_eff.cnt != '0) cen_vld_ff[cmd.addr] <= 1'b1;
         cen_rdv_ff <= cen_vld_ff[cmd.addr];
      end
   end

   assign cen_eff = cen_rdv_ff ? cen_rd_ff : '0;

   // accumulator table
   assign acc_raddr = cmd.acc_from_best ? bestk_ff : cmd.addr;
   assign acc_eff   = acc_rdv_ff ? acc_rd_ff : '0;

   always_comb begin
      acc_sum.x   = acc_eff.x + 30'(pix_ff.x);
      acc_sum.y   = acc_eff.y + 30'(pix_ff.y);
      acc_sum.l   = acc_eff.l + 28'(pix_ff.l);
      acc_sum.a   = acc_eff.a + 28'(pix_ff.a);
      acc_sum.b   = acc_eff.b + 28'(pix_ff.b);
      acc_sum.cnt = acc_eff.cnt + 21'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_wr) acc_mem[bestk_ff] <= acc_sum;
      if (cmd.acc_rd) acc_rd_ff <= acc_mem[acc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
         acc_rdv_ff <= 1'b0;
      end else begin
         if (cmd.acc_wr) acc_vld_ff[bestk_ff] <= 1'b1;
         else if (cmd.upd_wr) acc_vld_ff[cmd.addr] <= 1'b0;
         if (cmd.acc_rd) acc_rdv_ff <= acc_vld_ff[acc_raddr];
      end
   end

   // scan: read, differences, squares, products, compare
   always_ff @(posedge clock) begin
      k0_ff  <= cmd.addr;
      k1_ff  <= k0_ff;
      w1_ff  <= (absd10(pix_ff.x, cen_eff.x) < grid_ff) &&
                (absd10(pix_ff.y, cen_eff.y) < grid_ff);
      dx1_ff <= absd10(pix_ff.x, cen_eff.x);
      dy1_ff <= absd10(pix_ff.y, cen_eff.y);
      dl1_ff <= absd8(pix_ff.l, cen_eff.l);
      da1_ff <= absd8(pix_ff.a, cen_eff.a);
      db1_ff <= absd8(pix_ff.b, cen_eff.b);
      k2_ff  <= k1_ff;
      w2_ff  <= w1_ff;
      dc2_ff <= 18'(dl1_ff * dl1_ff) + 18'(da1_ff * da1_ff) + 18'(db1_ff * db1_ff);
      ds2_ff <= 21'(dx1_ff * dx1_ff) + 21'(dy1_ff * dy1_ff);
      k3_ff  <= k2_ff;
      w3_ff  <= w2_ff;
      pc_ff  <= dc2_ff * s2_ff;
      ps_ff  <= ds2_ff * m2_ff;
   end

   assign key = 39'(pc_ff) + 39'(ps_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         found_ff <= 1'b0;
         best_ff  <= '0;
         bestk_ff <= '0;
      end else begin
         v0_ff <= cmd.scan_issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (cmd.prep) begin
            found_ff <= 1'b0;
            best_ff  <= '0;
            bestk_ff <= '0;
         end else if (v3_ff && w3_ff && (!found_ff || key < best_ff)) begin
            // keep the first minimum
            found_ff <= 1'b1;
            best_ff  <= key;
            bestk_ff <= k3_ff;
         end
      end
   end

   assign sts.pipe_busy  = v0_ff || v1_ff || v2_ff || v3_ff;
   assign sts.count_zero = (acc_eff.cnt == '0);

   // restoring division, one quotient bit per step in each lane
   always_comb begin
      for (int i = 0; i < spau_pkg::DIV_LANES; i++) begin
         trial     = {rem_ff[i], dvd_ff[i][29]};
         dvd_in[i] = {dvd_ff[i][28:0], 1'b0};
         rem_in[i] = trial[20:0];
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in[i] = 21'(trial - {1'b0, dsr_ff});
            dvd_in[i][0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dsr_ff    <= acc_eff.cnt;
         dvd_ff[0] <= acc_eff.x;
         dvd_ff[1] <= acc_eff.y;
         dvd_ff[2] <= 30'(acc_eff.l);
         dvd_ff[3] <= 30'(acc_eff.a);
         dvd_ff[4] <= 30'(acc_eff.b);
         for (int i = 0; i < spau_pkg::DIV_LANES; i++) rem_ff[i] <= '0;
      end else if (cmd.div_step) begin
         for (int i = 0; i < spau_pkg::DIV_LANES; i++) begin
            dvd_ff[i] <= dvd_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   assign mean = '{x: dvd_ff[0][9:0], y: dvd_ff[1][9:0], l: dvd_ff[2][7:0],
                   a: dvd_ff[3][7:0], b: dvd_ff[4][7:0]};

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (cmd.rsp_classify) begin
            rsp_label          <= spau_pkg::LABEL_BITS'(bestk_ff);
            rsp_no_center_near <= !found_ff;
            rsp_best_distance  <= 40'(best_ff);
         end else begin
            rsp_label          <= '0;
            rsp_no_center_near <= 1'b0;
            rsp_best_distance  <= '0;
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/slic_pixel_assign_update_top.sv */
// SLIC superpixel k-means engine over a 64-entry center table. Op 0 loads one
// center. Op 1 classifies a pixel: the center table is read one slot per cycle
// into a four-stage distance pipeline (differences, squares, scaled products,
// add and compare), then the chosen center's sums are read and written back.
// Op 2 walks every center and uses the 30-step restoring divider that forms
// all five means in parallel lanes (a center with no members skips the divider).
// Reset clears the tables at once through per-entry valid bits, so no
// clearing pass is needed. One transaction is in flight at a time; a finished
// result waits in the output register while the next transaction is taken.
`default_nettype none
module slic_pixel_assign_update_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [5:0]  req_center_index,
   input  wire logic [9:0]  req_pos_x,
   input  wire logic [9:0]  req_pos_y,
   input  wire logic [7:0]  req_lum,
   input  wire logic [7:0]  req_chroma_a,
   input  wire logic [7:0]  req_chroma_b,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_label,
   output logic             rsp_no_center_near,
   output logic [39:0]      rsp_best_distance,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [9:0]  csr_wdata
);

   spau_pkg::cmd_type    cmd;
   spau_pkg::status_type sts;

   // sequencer: walks the slots and paces each transaction
   spau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // tables, distance pipeline, divider and result register
   spau_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_center_index   (req_center_index),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_lum            (req_lum),
      .req_chroma_a       (req_chroma_a),
      .req_chroma_b       (req_chroma_b),
      .req_op             (req_op),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_label          (rsp_label),
      .rsp_no_center_near (rsp_no_center_near),
      .rsp_best_distance  (rsp_best_distance)
   );

endmodule
`default_nettype wire

/* rtl/spau_checker.sv */
`default_nettype none
`include "slic_pixel_assign_update_top_defines.svh"
module spau_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [5:0]  rsp_label,
   input wire logic        rsp_no_center_near,
   input wire logic [39:0] rsp_best_distance
);

   `SPAU_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `SPAU_ASSERT(a_none_zero, rsp_valid && rsp_no_center_near |-> rsp_label == 6'd0 && rsp_best_distance == 40'd0, "no-center result carries a label or distance")
   `SPAU_ASSERT(a_busy_after, !reset && req_valid && !req_stall |=> req_stall, "took a second transaction without finishing the first")
   `SPAU_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result shown right after reset")

endmodule

bind slic_pixel_assign_update_top spau_checker u_chk (.*);
`default_nettype wire

/* verif/tb_slic_pixel_assign_update_top.sv */
`default_nettype none
module tb_slic_pixel_assign_update_top;

   // One request transaction as the driver presents it.
   typedef struct {
      logic [1:0] op;
      logic [5:0] idx;
      logic [9:0] px;
      logic [9:0] py;
      logic [7:0] pl;
      logic [7:0] pa;
      logic [7:0] pb;
   } pixel_req_type;

   // One response transaction as the monitor compares it.
   typedef struct {
      logic [5:0]  label;
      logic        far;
      logic [39:0] distance;
   } label_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [5:0]  req_center_index = '0;
   logic [9:0]  req_pos_x = '0;
   logic [9:0]  req_pos_y = '0;
   logic [7:0]  req_lum = '0;
   logic [7:0]  req_chroma_a = '0;
   logic [7:0]  req_chroma_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_label;
   logic        rsp_no_center_near;
   logic [39:0] rsp_best_distance;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [9:0]  csr_wdata = '0;

   slic_pixel_assign_update_top DUT (.*);

   always #10 clock = ~clock;

   // Predictor copy of the center table, the sums and the registers.
   logic [9:0]  m_cx [spau_pkg::NUM_CENTERS];
   logic [9:0]  m_cy [spau_pkg::NUM_CENTERS];
   logic [7:0]  m_cl [spau_pkg::NUM_CENTERS];
   logic [7:0]  m_ca [spau_pkg::NUM_CENTERS];
   logic [7:0]  m_cb [spau_pkg::NUM_CENTERS];
   logic [29:0] m_sx [spau_pkg::NUM_CENTERS];
   logic [29:0] m_sy [spau_pkg::NUM_CENTERS];
   logic [27:0] m_sl [spau_pkg::NUM_CENTERS];
   logic [27:0] m_sa [spau_pkg::NUM_CENTERS];
   logic [27:0] m_sb [spau_pkg::NUM_CENTERS];
   logic [20:0] m_cnt [spau_pkg::NUM_CENTERS];
   logic [9:0]  m_step;
   logic [7:0]  m_compact;

   pixel_req_type pending_reqs [$];
   label_rsp_type expected_labels [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 1'b0;
   bit  hold_go = 1'b0;
   int  mismatches = 0;
   longint cycles = 0;

   function automatic longint unsigned adiff(longint unsigned p, longint unsigned q);
      return (p > q) ? p - q : q - p;
   endfunction

   // Append one request to the tail of the pending queue.
   function automatic void enqueue_req(pixel_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // Compute the response for one request and advance the predicted state.
   function automatic label_rsp_type assign_pixel(pixel_req_type r);
      label_rsp_type res;
      longint unsigned s2, m2, dx, dy, dl, da, db, key, best, n;
      int bestk;
      bit found;
      res.label = '0;
      res.far = 1'b0;
      res.distance = '0;
      if (r.op == spau_pkg::OP_LOAD) begin
         m_cx[r.idx] = r.px;
         m_cy[r.idx] = r.py;
         m_cl[r.idx] = r.pl;
         m_ca[r.idx] = r.pa;
         m_cb[r.idx] = r.pb;
      end else if (r.op == spau_pkg::OP_CLASSIFY) begin
         s2 = m_step * m_step;
         m2 = m_compact * m_compact;
         found = 1'b0;
         best = 0;
         bestk = 0;
         for (int k = 0; k < spau_pkg::NUM_CENTERS; k++) begin
            dx = adiff(r.px, m_cx[k]);
            dy = adiff(r.py, m_cy[k]);
            if (dx >= m_step || dy >= m_step) continue;
            dl = adiff(r.pl, m_cl[k]);
            da = adiff(r.pa, m_ca[k]);
            db = adiff(r.pb, m_cb[k]);
            key = (dl * dl + da * da + db * db) * s2 + (dx * dx + dy * dy) * m2;
            if (!found || key < best) begin
               found = 1'b1;
               best = key;
               bestk = k;
            end
         end
         if (found) begin
            res.label = bestk[5:0];
            res.distance = best[39:0];
         end else begin
            res.far = 1'b1;
         end
         m_sx[bestk] += r.px;
         m_sy[bestk] += r.py;
         m_sl[bestk] += r.pl;
         m_sa[bestk] += r.pa;
         m_sb[bestk] += r.pb;
         m_cnt[bestk] += 1;
      end else if (r.op == spau_pkg::OP_UPDATE) begin
         for (int k = 0; k < spau_pkg::NUM_CENTERS; k++) begin
            n = m_cnt[k];
            if (n != 0) begin
               m_cx[k] = 10'(m_sx[k] / n);
               m_cy[k] = 10'(m_sy[k] / n);
               m_cl[k] = 8'(m_sl[k] / n);
               m_ca[k] = 8'(m_sa[k] / n);
               m_cb[k] = 8'(m_sb[k] / n);
            end
            m_sx[k] = '0;
            m_sy[k] = '0;
            m_sl[k] = '0;
            m_sa[k] = '0;
            m_sb[k] = '0;
            m_cnt[k] = '0;
         end
      end
      return res;
   endfunction

   // Driver: present the head of the pending queue, advance on acceptance.
   // Predict at acceptance so the expected order matches the block's order.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_labels.insert(expected_labels.size(),
                                   assign_pixel(pending_reqs.pop_front()));
         end
         // Hold a stalled transaction; otherwise pick the next one or idle.
         if (!(req_valid && req_stall)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_op <= pending_reqs[0].op;
               req_center_index <= pending_reqs[0].idx;
               req_pos_x <= pending_reqs[0].px;
               req_pos_y <= pending_reqs[0].py;
               req_lum <= pending_reqs[0].pl;
               req_chroma_a <= pending_reqs[0].pa;
               req_chroma_b <= pending_reqs[0].pb;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random, or forced high during a long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // Long receiver hold-off, counted in cycles once started.
   initial begin : hold_off
      wait (hold_go);
      recv_hold <= 1'b1;
      repeat (600) @(posedge clock);
      recv_hold <= 1'b0;
   end

   // Monitor: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      label_rsp_type exp_rsp;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_labels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response label=%0d", rsp_label);
         end else begin
            exp_rsp = expected_labels.pop_front();
            if (rsp_label !== exp_rsp.label || rsp_no_center_near !== exp_rsp.far ||
                rsp_best_distance !== exp_rsp.distance) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp label=%0d far=%0d dist=%0d got label=%0d far=%0d dist=%0d",
                           exp_rsp.label, exp_rsp.far, exp_rsp.distance,
                           rsp_label, rsp_no_center_near, rsp_best_distance);
            end
         end
      end
   end

   // Timeout guard: the slowest run is well under this bound.
   always @(posedge clock) begin
      if (cycles > 64'd3_000_000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic pixel_req_type mk(logic [1:0] op, logic [5:0] idx, logic [9:0] px,
                                       logic [9:0] py, logic [7:0] pl, logic [7:0] pa,
                                       logic [7:0] pb);
      pixel_req_type r;
      r.op = op; r.idx = idx; r.px = px; r.py = py; r.pl = pl; r.pa = pa; r.pb = pb;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_labels.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Write one register while the block is idle.
   task automatic csr_write(logic addr, logic [9:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == spau_pkg::CSR_GRID_STEP) m_step = val;
      else m_compact = val[7:0];
   endtask

   // Queue a grid of centers, then random pixels near them, then an update.
   task automatic queue_frame(int n_pix, int spacing, int span);
      int nc;
      nc = $urandom_range(4, spau_pkg::NUM_CENTERS);
      for (int c = 0; c < nc; c++)
         enqueue_req(mk(spau_pkg::OP_LOAD, 6'(c),
                        10'((c % 8) * spacing + $urandom_range(3)),
                        10'((c / 8) * spacing + $urandom_range(3)),
                        8'($urandom), 8'($urandom), 8'($urandom)));
      for (int i = 0; i < n_pix; i++) begin
         if ($urandom_range(9) == 0)
            enqueue_req(mk(2'($urandom), 6'($urandom), 10'($urandom), 10'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom)));
         else
            enqueue_req(mk(spau_pkg::OP_CLASSIFY, 6'($urandom), 10'($urandom_range(span)),
                           10'($urandom_range(span)), 8'($urandom),
                           8'($urandom), 8'($urandom)));
      end
      enqueue_req(mk(spau_pkg::OP_UPDATE, '0, '0, '0, '0, '0, '0));
   endtask

   initial begin
      for (int k = 0; k < spau_pkg::NUM_CENTERS; k++) begin
         m_cx[k] = '0; m_cy[k] = '0; m_cl[k] = '0; m_ca[k] = '0; m_cb[k] = '0;
         m_sx[k] = '0; m_sy[k] = '0; m_sl[k] = '0; m_sa[k] = '0; m_sb[k] = '0;
         m_cnt[k] = '0;
      end
      m_step = 10'd16;
      m_compact = 8'd10;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset defaults, field extremes, all ops, no-center case,
      // empty centers at update, the unused op code.
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, '0, '0, '0, '0, '0));
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, 6'd63, 10'd1023, 10'd1023, 8'd255, 8'd255,
                     8'd255));
      enqueue_req(mk(spau_pkg::OP_LOAD, 6'd63, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255));
      enqueue_req(mk(spau_pkg::OP_LOAD, 6'd1, 10'd5, 10'd5, 8'd0, 8'd255, 8'd0));
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd1020, 10'd1010, 8'd255, 8'd0, 8'd255));
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd3, 10'd4, 8'd0, 8'd0, 8'd0));
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd500, 10'd500, 8'd1, 8'd2, 8'd3));
      enqueue_req(mk(2'd3, 6'd63, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255));
      enqueue_req(mk(spau_pkg::OP_UPDATE, '0, '0, '0, '0, '0, '0));
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd1, 10'd1, 8'd9, 8'd9, 8'd9));
      enqueue_req(mk(spau_pkg::OP_UPDATE, '0, '0, '0, '0, '0, '0));
      wait_drained();

      // Extreme register settings.
      csr_write(spau_pkg::CSR_GRID_STEP, 10'd1023);
      csr_write(spau_pkg::CSR_COMPACTNESS, 8'd255);
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd0, 10'd1023, 8'd128, 8'd7, 8'd200));
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd1023, 10'd0, 8'd0, 8'd255, 8'd0));
      wait_drained();
      csr_write(spau_pkg::CSR_GRID_STEP, 10'd1);
      csr_write(spau_pkg::CSR_COMPACTNESS, 8'd1);
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd5, 10'd5, 8'd0, 8'd255, 8'd0));
      enqueue_req(mk(spau_pkg::OP_CLASSIFY, '0, 10'd6, 10'd5, 8'd0, 8'd255, 8'd0));
      wait_drained();

      // Phase one: sender sparse idling, receiver heavy stalls.
      send_idle_pct = 23; recv_idle_pct = 79;
      csr_write(spau_pkg::CSR_GRID_STEP, 10'd40);
      csr_write(spau_pkg::CSR_COMPACTNESS, 8'd20);
      queue_frame(250, 30, 260);
      queue_frame(250, 30, 260);
      wait_drained();

      // Phase two: the other way round, with a long receiver hold-off while
      // items keep coming, so the block fills and stalls its input.
      send_idle_pct = 79; recv_idle_pct = 23;
      csr_write(spau_pkg::CSR_GRID_STEP, 10'd120);
      csr_write(spau_pkg::CSR_COMPACTNESS, 8'd255);
      hold_go <= 1'b1;
      queue_frame(300, 120, 1023);
      wait_drained();

      // Phase three: no idling; small steps make the far case common.
      send_idle_pct = 0; recv_idle_pct = 0;
      csr_write(spau_pkg::CSR_GRID_STEP, 10'd8);
      csr_write(spau_pkg::CSR_COMPACTNESS, 8'd3);
      queue_frame(350, 12, 100);
      wait_drained();
      csr_write(spau_pkg::CSR_GRID_STEP, 10'd16);
      csr_write(spau_pkg::CSR_COMPACTNESS, 8'd10);
      queue_frame(350, 16, 140);
      wait_drained();

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
